// File: rtl/rlec_pkg.sv
// ----------------------------------------------------------------------------
// rlec_pkg
// Shared codes, widths and small tables of the rgb led effect controller.
// ----------------------------------------------------------------------------
package rlec_pkg;

  localparam int DIV_NW = 40;   // dividend width of the serial divider
  localparam int DIV_DW = 16;   // divisor width of the serial divider
  localparam int MUL_W  = 32;   // operand width of the serial multiplier

  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  localparam logic [1:0] OP_USER   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_NET    = 2'd2;
  localparam logic [1:0] OP_SYSTEM = 2'd3;

  localparam logic [7:0] IDX_ALL   = 8'hFF;
  localparam logic [7:0] IDX_CLEAR = 8'hFE;

  localparam logic [7:0] EFF_SOLID = 8'd0;
  localparam logic [7:0] EFF_BLINK = 8'd1;
  localparam logic [7:0] EFF_FADE  = 8'd2;

  localparam logic [1:0] NS_OFF    = 2'd0;
  localparam logic [1:0] NS_WLAN   = 2'd1;
  localparam logic [1:0] NS_WIRED  = 2'd2;
  localparam logic [1:0] NS_ONLINE = 2'd3;

  localparam logic [7:0] NET_LEVEL = 8'd40;

  localparam logic CFG_TICK_STEP      = 1'b0;
  localparam logic CFG_DEFAULT_PERIOD = 1'b1;

  localparam logic [9:0]  TICK_STEP_RESET      = 10'd20;
  localparam logic [15:0] DEFAULT_PERIOD_RESET = 16'd500;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // taylor series denominator (2n)(2n+1)
  function automatic logic [7:0] taylor_den(input logic [2:0] n);
    logic [7:0] d;
    case (n)
      3'd1: d = 8'd6;
      3'd2: d = 8'd20;
      3'd3: d = 8'd42;
      3'd4: d = 8'd72;
      3'd5: d = 8'd110;
      3'd6: d = 8'd156;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/rlec_mul.sv
// ----------------------------------------------------------------------------
// rlec_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rlec_mul (
  input  logic              clk,
  input  logic              rst,
  input  rlec_pkg::mul_req_t req,
  output logic              done,
  output logic [63:0]       product
);
  import rlec_pkg::*;

  logic [MUL_W-1:0] mcand;
  logic [63:0]      prod;
  logic [5:0]       cnt;
  logic             busy;
  logic [MUL_W:0]   psum;

  assign psum    = {1'b0, prod[63:32]} + (prod[0] ? {1'b0, mcand} : '0);
  assign product = prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        prod <= {psum, prod[31:1]};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        mcand <= req.a;
        prod  <= {32'd0, req.b};
        cnt   <= 6'(MUL_W);
        busy  <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/rlec_div.sv
// ----------------------------------------------------------------------------
// rlec_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlec_div (
  input  logic                       clk,
  input  logic                       rst,
  input  rlec_pkg::div_req_t         req,
  output logic                       done,
  output logic [rlec_pkg::DIV_NW-1:0] quotient,
  output logic [rlec_pkg::DIV_DW-1:0] remainder
);
  import rlec_pkg::*;

  logic [DIV_DW-1:0] dsor;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem;
  logic [5:0]        cnt;
  logic              busy;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  assign rem_sh    = {rem, quo[DIV_NW-1]};
  assign ge        = rem_sh >= {1'b0, dsor};
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        rem  <= ge ? DIV_DW'(rem_sh - {1'b0, dsor}) : DIV_DW'(rem_sh);
        quo  <= {quo[DIV_NW-2:0], ge};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        dsor <= req.divisor;
        quo  <= req.dividend;
        rem  <= '0;
        cnt  <= 6'(DIV_NW);
        busy <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/rlec_sine.sv
// ----------------------------------------------------------------------------
// rlec_sine
// Sine of pi*q/2^PHASE_BITS in unsigned Q0.16 by a serial Taylor series.
// ----------------------------------------------------------------------------
module rlec_sine #(
  parameter int PHASE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [PHASE_BITS-1:0] q,
  output logic                  done,
  output logic [15:0]           s
);
  import rlec_pkg::*;

  typedef enum logic [5:0] {
    SI_IDLE = 6'b000001,
    SI_X    = 6'b000010,
    SI_X2   = 6'b000100,
    SI_TM   = 6'b001000,
    SI_TD   = 6'b010000,
    SI_FIN  = 6'b100000
  } si_state_t;

  si_state_t         state;
  logic [31:0]       term;
  logic [31:0]       sum;
  logic [31:0]       x2;
  logic [2:0]        n;
  mul_req_t          mreq;
  div_req_t          dreq;
  logic              mdone;
  logic              ddone;
  logic [63:0]       prod;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] rem_unused;
  logic [PHASE_BITS:0]   full_m_q;
  logic [PHASE_BITS-1:0] k;
  logic [31:0]       tnew;
  logic [31:0]       sum_next;
  logic [48:0]       scaled;
  logic [18:0]       rnd;

  rlec_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mdone), .product(prod));
  rlec_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone),
                  .quotient(quo), .remainder(rem_unused));

  // mirror around the half period
  assign full_m_q = (PHASE_BITS+1)'(1 << PHASE_BITS) - {1'b0, q};
  assign k = (q > PHASE_BITS'(1 << (PHASE_BITS - 1))) ? full_m_q[PHASE_BITS-1:0] : q;

  assign tnew = quo[31:0];
  always_comb begin
    if (n[0]) begin
      sum_next = (sum > tnew) ? sum - tnew : 32'd0;
    end else begin
      sum_next = sum + tnew;
    end
  end

  assign scaled = {1'b0, sum, 16'd0} - {17'd0, sum} + 49'(1 << 29);
  assign rnd    = scaled[48:30];

  always_comb begin
    mreq = '0;
    dreq = '0;
    case (state)
      SI_IDLE: begin
        mreq.start = start;
        mreq.a     = PI_Q30;
        mreq.b     = 32'(k);
      end
      SI_X: begin
        mreq.start = mdone;
        mreq.a     = prod[PHASE_BITS +: 32];
        mreq.b     = prod[PHASE_BITS +: 32];
      end
      SI_X2: begin
        mreq.start = mdone;
        mreq.a     = term;
        mreq.b     = prod[61:30];
      end
      SI_TM: begin
        dreq.start    = mdone;
        dreq.dividend = DIV_NW'(prod[63:30]);
        dreq.divisor  = DIV_DW'(taylor_den(n));
      end
      SI_TD: begin
        mreq.start = ddone && (n != 3'd6);
        mreq.a     = tnew;
        mreq.b     = x2;
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SI_IDLE;
      done  <= 1'b0;
      n     <= 3'd1;
    end else begin
      done <= 1'b0;
      case (state)
        SI_IDLE: begin
          if (start) state <= SI_X;
        end
        SI_X: begin
          if (mdone) begin
            term  <= prod[PHASE_BITS +: 32];
            sum   <= prod[PHASE_BITS +: 32];
            state <= SI_X2;
          end
        end
        SI_X2: begin
          if (mdone) begin
            x2    <= prod[61:30];
            n     <= 3'd1;
            state <= SI_TM;
          end
        end
        SI_TM: begin
          if (mdone) state <= SI_TD;
        end
        SI_TD: begin
          if (ddone) begin
            term <= tnew;
            sum  <= sum_next;
            if (n == 3'd6) begin
              state <= SI_FIN;
            end else begin
              n     <= n + 3'd1;
              state <= SI_TM;
            end
          end
        end
        SI_FIN: begin
          s     <= (rnd > 19'd65535) ? 16'hFFFF : rnd[15:0];
          done  <= 1'b1;
          state <= SI_IDLE;
        end
        default: state <= SI_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/rgb_led_effect_controller.sv
// ----------------------------------------------------------------------------
// rgb_led_effect_controller
// LED table with solid, blink and sine fade effects, emitting GRB frames.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                    | content
//  s_axis   | in  | tvalid/tready                | command, tick, status, system
//  m_axis   | out | tvalid/tready, tlast         | one GRB colour per LED
//  cfg      | in  | cfg_we, no wait              | tick step, default period
//
// a tick walks LEDs 1 up; a blink LED needs the modulo divider, a fade LED the
// modulo and phase divides plus the sine unit. one item is in work at a time;
// tready is low until its frame is fully taken. output stalls hold the frame;
// reset clears the whole table at once.
module rgb_led_effect_controller #(
  parameter int LED_COUNT  = 12,
  parameter int PHASE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // led_index, red, green, blue, effect_code, period_ms, net_status, zero pad
  input  logic [63:0] s_axis_tdata,
  // operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // led_number, out_green, out_red, out_blue, zero pad
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import rlec_pkg::*;

  localparam int CW  = $clog2(LED_COUNT + 1);
  localparam int LIW = $clog2(LED_COUNT);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_MOD   = 7'b0000100,
    ST_PHASE = 7'b0001000,
    ST_SINE  = 7'b0010000,
    ST_WB    = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t      state;
  logic [9:0]  tick_step;
  logic [15:0] default_period;

  logic [23:0] set_colour    [LED_COUNT];
  logic [7:0]  effect_mode   [LED_COUNT];
  logic [15:0] effect_period [LED_COUNT];
  logic [15:0] elapsed_time  [LED_COUNT];
  logic [23:0] shown_colour  [LED_COUNT];

  logic [CW-1:0] i;
  logic          dirty;
  logic [15:0]   el;
  logic [15:0]   sval;

  logic [1:0]  in_op;
  logic [7:0]  in_idx;
  logic [7:0]  in_r, in_g, in_b, in_eff;
  logic [15:0] in_per;
  logic [1:0]  in_net;
  logic        accept;
  logic        idx_single;
  logic [15:0] cmd_per;
  logic [23:0] net_col;

  logic [LIW-1:0] ci;
  logic [7:0]     cur_mode;
  logic [15:0]    cur_per;
  logic [23:0]    cur_set;
  logic [16:0]    tsum;

  div_req_t          dreq;
  logic              ddone;
  logic [DIV_NW-1:0] dquo;
  logic [DIV_DW-1:0] drem;
  logic              sine_start;
  logic              sine_done;
  logic [15:0]       sine_s;

  logic [23:0] pr, pg, pb;
  logic [23:0] fade_col;

  logic            ovalid;
  logic [CW+3:0]   cnt_ext;
  logic [CW-1:0]   ocnt;
  logic            out_free;

  assign in_op  = s_axis_tuser;
  assign in_idx = s_axis_tdata[7:0];
  assign in_r   = s_axis_tdata[15:8];
  assign in_g   = s_axis_tdata[23:16];
  assign in_b   = s_axis_tdata[31:24];
  assign in_eff = s_axis_tdata[39:32];
  assign in_per = s_axis_tdata[55:40];
  assign in_net = s_axis_tdata[57:56];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx_single    = (in_idx >= 8'd2) && (in_idx < 8'(LED_COUNT));
  assign cmd_per       = (in_per != 16'd0) ? in_per : default_period;

  always_comb begin
    case (in_net)
      NS_ONLINE: net_col = {8'd0, NET_LEVEL, 8'd0};
      NS_WIRED:  net_col = {NET_LEVEL, NET_LEVEL, 8'd0};
      NS_WLAN:   net_col = {8'd0, 8'd0, NET_LEVEL};
      default:   net_col = 24'd0;
    endcase
  end

  assign ci       = i[LIW-1:0];
  assign cur_mode = effect_mode[ci];
  assign cur_per  = effect_period[ci];
  assign cur_set  = set_colour[ci];
  assign tsum     = {1'b0, elapsed_time[ci]} + {7'd0, tick_step};

  // channel times sine, truncated
  assign pr       = cur_set[23:16] * sval;
  assign pg       = cur_set[15:8] * sval;
  assign pb       = cur_set[7:0] * sval;
  assign fade_col = {pr[23:16], pg[23:16], pb[23:16]};

  // led number is the low four bits of the output counter
  function automatic logic [3:0] cnt_ext_low(input logic [CW-1:0] c);
    logic [CW+3:0] w;
    w = {4'd0, c};
    return w[3:0];
  endfunction

  always_comb begin
    dreq = '0;
    case (state)
      ST_SCAN: begin
        dreq.start    = (i != CW'(LED_COUNT)) && (cur_mode != EFF_SOLID)
                        && (cur_per != 16'd0);
        dreq.dividend = DIV_NW'(tsum);
        dreq.divisor  = cur_per;
      end
      ST_MOD: begin
        dreq.start    = ddone && (cur_mode == EFF_FADE);
        dreq.dividend = DIV_NW'({drem, {PHASE_BITS{1'b0}}});
        dreq.divisor  = cur_per;
      end
      default: dreq = '0;
    endcase
  end

  assign sine_start = (state == ST_PHASE) && ddone;

  rlec_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone),
                  .quotient(dquo), .remainder(drem));

  rlec_sine #(.PHASE_BITS(PHASE_BITS)) u_sine (
    .clk(clk), .rst(rst), .start(sine_start), .q(dquo[PHASE_BITS-1:0]),
    .done(sine_done), .s(sine_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step      <= TICK_STEP_RESET;
      default_period <= DEFAULT_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICK_STEP:      tick_step <= cfg_data[9:0];
        CFG_DEFAULT_PERIOD: default_period <= cfg_data;
        default:            tick_step <= tick_step;
      endcase
    end
  end

  assign out_free = !ovalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      i      <= '0;
      dirty  <= 1'b0;
      ovalid <= 1'b0;
      ocnt   <= '0;
      for (int j = 0; j < LED_COUNT; j++) begin
        set_colour[j]    <= '0;
        effect_mode[j]   <= '0;
        effect_period[j] <= '0;
        elapsed_time[j]  <= '0;
        shown_colour[j]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          ocnt <= '0;
          if (accept) begin
            case (in_op)
              OP_USER: begin
                for (int j = 2; j < LED_COUNT; j++) begin
                  if (in_idx == IDX_CLEAR) begin
                    set_colour[j]    <= '0;
                    effect_mode[j]   <= EFF_SOLID;
                    effect_period[j] <= default_period;
                    elapsed_time[j]  <= '0;
                    shown_colour[j]  <= '0;
                  end else if (in_idx == IDX_ALL || (idx_single && in_idx == 8'(j))) begin
                    set_colour[j]    <= {in_r, in_g, in_b};
                    effect_mode[j]   <= in_eff;
                    effect_period[j] <= cmd_per;
                    elapsed_time[j]  <= '0;
                    if (in_eff == EFF_SOLID) shown_colour[j] <= {in_r, in_g, in_b};
                  end
                end
                if (in_idx == IDX_ALL || in_idx == IDX_CLEAR || idx_single) begin
                  state <= ST_EMIT;
                end
              end
              OP_TICK: begin
                i     <= CW'(1);
                dirty <= 1'b0;
                state <= ST_SCAN;
              end
              OP_NET: begin
                set_colour[1]    <= net_col;
                effect_mode[1]   <= EFF_SOLID;
                effect_period[1] <= default_period;
                elapsed_time[1]  <= '0;
                shown_colour[1]  <= net_col;
                state            <= ST_EMIT;
              end
              default: begin
                shown_colour[0] <= {in_r, in_g, in_b};
                state           <= ST_EMIT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (i == CW'(LED_COUNT)) begin
            state <= dirty ? ST_EMIT : ST_IDLE;
          end else if (cur_mode == EFF_SOLID) begin
            i <= i + CW'(1);
          end else begin
            dirty <= 1'b1;
            if (cur_per == 16'd0) begin
              el    <= '0;
              sval  <= '0;
              state <= ST_WB;
            end else begin
              state <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (ddone) begin
            el    <= drem;
            state <= (cur_mode == EFF_FADE) ? ST_PHASE : ST_WB;
          end
        end
        ST_PHASE: begin
          if (ddone) state <= ST_SINE;
        end
        ST_SINE: begin
          if (sine_done) begin
            sval  <= sine_s;
            state <= ST_WB;
          end
        end
        ST_WB: begin
          elapsed_time[ci] <= el;
          if (cur_mode == EFF_BLINK) begin
            shown_colour[ci] <= (el < (cur_per >> 1)) ? cur_set : 24'd0;
          end else if (cur_mode == EFF_FADE) begin
            shown_colour[ci] <= fade_col;
          end
          i     <= i + CW'(1);
          state <= ST_SCAN;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (ocnt != CW'(LED_COUNT)) begin
              ovalid <= 1'b1;
              cnt_ext <= {4'd0, ocnt};
              m_axis_tdata <= {4'd0, shown_colour[ocnt[LIW-1:0]][7:0],
                               shown_colour[ocnt[LIW-1:0]][23:16],
                               shown_colour[ocnt[LIW-1:0]][15:8],
                               cnt_ext_low(ocnt)};
              m_axis_tlast <= (ocnt == CW'(LED_COUNT - 1));
              ocnt <= ocnt + CW'(1);
            end else begin
              ovalid <= 1'b0;
              state  <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid;

`ifndef NO_ASSERTIONS
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == ST_EMIT)
    else $error("output valid outside frame emission");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> state == ST_IDLE)
    else $error("frame did not end after its last item");

  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> cnt_ext[3:0] == m_axis_tdata[3:0])
    else $error("led number does not match the output counter");
`endif

endmodule

// File: tb/rgb_led_effect_controller_test.sv
// ----------------------------------------------------------------------------
// rgb_led_effect_controller_test
// Self-checking bench: directed and random commands, ticks, status and system
// items under random stalls on both sides; every GRB frame is predicted and
// checked field by field.
// ----------------------------------------------------------------------------
module rgb_led_effect_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rlec_pkg::*;

  localparam int LED_TOTAL = 12;
  localparam int PH_BITS  = 10;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] data;
  } cmd_item_t;

  typedef struct {
    logic [3:0] num;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
    logic       last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  rgb_led_effect_controller u_dut (.*);

  cmd_item_t pending_cmds[$];
  pixel_t    expected_pixels[$];
  int        error_count = 0;
  int        send_idle_pct = 17;
  int        recv_idle_pct = 79;
  logic      hold_armed = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;

  // shadow of the led table and registers
  logic [9:0]  step_ms = TICK_STEP_RESET;
  logic [15:0] dflt_period = DEFAULT_PERIOD_RESET;
  logic [23:0] set_col[LED_TOTAL];
  logic [7:0]  mode[LED_TOTAL];
  logic [15:0] period[LED_TOTAL];
  logic [15:0] elapsed[LED_TOTAL];
  logic [23:0] shown[LED_TOTAL];

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [31:0] sine_q16(logic [31:0] q);
    logic [63:0] k, x, x2, term, sum;
    k = (q > (1 << (PH_BITS - 1))) ? (64'(1) << PH_BITS) - q : 64'(q);
    x = (64'(PI_Q30) * k) >> PH_BITS;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = (sum > term) ? sum - term : 64'd0;
      else sum = sum + term;
    end
    sum = (sum * 64'd65535 + (64'd1 << 29)) >> 30;
    return (sum > 65535) ? 32'd65535 : sum[31:0];
  endfunction

  function automatic void set_led(int i, logic [23:0] col, logic [7:0] eff, logic [15:0] per);
    set_col[i] = col;
    mode[i] = eff;
    period[i] = (per != 0) ? per : dflt_period;
    elapsed[i] = '0;
    if (eff == EFF_SOLID) shown[i] = col;
  endfunction

  function automatic void push_frame();
    pixel_t p;
    for (int i = 0; i < LED_TOTAL; i++) begin
      p.num = i[3:0];
      p.r = shown[i][23:16];
      p.g = shown[i][15:8];
      p.b = shown[i][7:0];
      p.last = (i == LED_TOTAL - 1);
      expected_pixels.push_back(p);
    end
  endfunction

  function automatic bit advance_leds();
    bit any;
    logic [31:0] el, s, per;
    logic [23:0] c;
    any = 0;
    for (int i = 1; i < LED_TOTAL; i++) begin
      if (mode[i] != EFF_SOLID) begin
        per = period[i];
        c = set_col[i];
        el = (per != 0) ? (32'(elapsed[i]) + step_ms) % per : 32'd0;
        elapsed[i] = el[15:0];
        if (mode[i] == EFF_BLINK) begin
          shown[i] = (el < per / 2) ? c : 24'd0;
        end else if (mode[i] == EFF_FADE) begin
          s = (per != 0) ? sine_q16((el << PH_BITS) / per) : 32'd0;
          shown[i] = {8'((32'(c[23:16]) * s) >> 16), 8'((32'(c[15:8]) * s) >> 16),
                      8'((32'(c[7:0]) * s) >> 16)};
        end
        any = 1;
      end
    end
    return any;
  endfunction

  function automatic void predict_frame(cmd_item_t it);
    logic [7:0] idx, r, g, b, eff;
    logic [15:0] per;
    logic [1:0] net;
    {net, per, eff, b, g, r, idx} = it.data[57:0];
    case (it.op)
      OP_USER: begin
        if (idx == IDX_ALL) begin
          for (int i = 2; i < LED_TOTAL; i++) set_led(i, {r, g, b}, eff, per);
          push_frame();
        end else if (idx == IDX_CLEAR) begin
          for (int i = 2; i < LED_TOTAL; i++) set_led(i, 24'd0, EFF_SOLID, 16'd0);
          push_frame();
        end else if (idx >= 2 && idx < LED_TOTAL) begin
          set_led(idx, {r, g, b}, eff, per);
          push_frame();
        end
      end
      OP_TICK: if (advance_leds()) push_frame();
      OP_NET: begin
        case (net)
          NS_ONLINE: set_led(1, {8'd0, NET_LEVEL, 8'd0}, EFF_SOLID, 16'd0);
          NS_WIRED:  set_led(1, {NET_LEVEL, NET_LEVEL, 8'd0}, EFF_SOLID, 16'd0);
          NS_WLAN:   set_led(1, {16'd0, NET_LEVEL}, EFF_SOLID, 16'd0);
          default:   set_led(1, 24'd0, EFF_SOLID, 16'd0);
        endcase
        push_frame();
      end
      default: begin
        shown[0] = {r, g, b};
        push_frame();
      end
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) predict_frame('{s_axis_tuser, s_axis_tdata});
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_item_t it;
        it = pending_cmds.pop_front();
        s_axis_tuser <= it.op;
        s_axis_tdata <= it.data;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (hold_armed && !hold_done && m_axis_tvalid) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected item: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        pixel_t p;
        p = expected_pixels.pop_front();
        if (m_axis_tdata[3:0] !== p.num) begin
          $error("led_number expected %0d got %0d", p.num, m_axis_tdata[3:0]);
          error_count++;
        end
        if (m_axis_tdata[11:4] !== p.g) begin
          $error("out_green expected %0d got %0d", p.g, m_axis_tdata[11:4]);
          error_count++;
        end
        if (m_axis_tdata[19:12] !== p.r) begin
          $error("out_red expected %0d got %0d", p.r, m_axis_tdata[19:12]);
          error_count++;
        end
        if (m_axis_tdata[27:20] !== p.b) begin
          $error("out_blue expected %0d got %0d", p.b, m_axis_tdata[27:20]);
          error_count++;
        end
        if (m_axis_tlast !== p.last) begin
          $error("last_led expected %0d got %0d", p.last, m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  function automatic cmd_item_t make_cmd(logic [1:0] op, logic [7:0] idx, logic [7:0] r,
      logic [7:0] g, logic [7:0] b, logic [7:0] eff, logic [15:0] per, logic [1:0] net);
    cmd_item_t it;
    it.op = op;
    it.data = {6'd0, net, per, eff, b, g, r, idx};
    return it;
  endfunction

  function automatic cmd_item_t random_cmd();
    cmd_item_t it;
    int sel;
    logic [7:0] idx, eff;
    logic [15:0] per;
    it.data = {$urandom, $urandom};
    it.data[63:58] = '0;
    sel = $urandom_range(99);
    it.op = (sel < 40) ? OP_USER : (sel < 75) ? OP_TICK : (sel < 85) ? OP_NET : OP_SYSTEM;
    sel = $urandom_range(99);
    idx = (sel < 75) ? 8'($urandom_range(2, LED_TOTAL - 1)) : (sel < 83) ? IDX_ALL :
          (sel < 90) ? IDX_CLEAR : 8'($urandom);
    sel = $urandom_range(99);
    eff = (sel < 90) ? 8'($urandom_range(2)) : 8'($urandom);
    sel = $urandom_range(99);
    per = (sel < 60) ? 16'($urandom_range(1, 2000)) : (sel < 75) ? 16'd0 : 16'($urandom);
    it.data[7:0] = idx;
    it.data[39:32] = eff;
    it.data[55:40] = per;
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (9000) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TICK_STEP) step_ms = value[9:0];
    else dflt_period = value;
  endtask

  initial begin
    for (int i = 0; i < LED_TOTAL; i++) begin
      set_col[i] = '0; mode[i] = '0; period[i] = '0; elapsed[i] = '0; shown[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    pending_cmds.push_back(make_cmd(OP_TICK, 8'h00, 0, 0, 0, 0, 0, NS_OFF));
    pending_cmds.push_back(make_cmd(OP_SYSTEM, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 2'd3));
    pending_cmds.push_back(make_cmd(OP_SYSTEM, 8'hA5, 8'h12, 8'h00, 8'h80, 0, 0, NS_OFF));
    pending_cmds.push_back(make_cmd(OP_NET, 0, 0, 0, 0, 0, 0, NS_OFF));
    pending_cmds.push_back(make_cmd(OP_NET, 0, 0, 0, 0, 0, 0, NS_WLAN));
    pending_cmds.push_back(make_cmd(OP_NET, 8'hFF, 1, 2, 3, 8'd1, 5, NS_WIRED));
    pending_cmds.push_back(make_cmd(OP_NET, 0, 0, 0, 0, 0, 0, NS_ONLINE));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd0, 8'hFF, 8'hFF, 8'hFF, EFF_BLINK, 100, 0));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd1, 8'hFF, 8'hFF, 8'hFF, EFF_FADE, 100, 0));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd12, 8'hFF, 0, 0, EFF_SOLID, 0, 0));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd253, 8'hFF, 0, 0, EFF_SOLID, 0, 0));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd2, 8'hFF, 8'h01, 8'h80, EFF_SOLID, 0, 0));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd11, 8'hC0, 8'hFF, 8'h0F, EFF_BLINK, 0, 0));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd3, 8'hFF, 8'hFF, 8'hFF, EFF_FADE, 16'd1, 0));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd4, 8'hFF, 8'h80, 8'h40, EFF_FADE, 16'hFFFF, 0));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd5, 8'hFF, 8'hFF, 8'hFF, 8'd200, 16'd77, 0));
    pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 3));
    pending_cmds.push_back(make_cmd(OP_USER, IDX_ALL, 8'hFF, 8'hFF, 8'hFF, EFF_FADE, 16'd40, 0));
    pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_USER, IDX_CLEAR, 8'hFF, 8'hFF, 8'hFF, EFF_FADE, 9, 0));
    // nothing animated: no frame
    pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // zero default period and the smallest nonzero step
    write_reg(CFG_DEFAULT_PERIOD, 16'd0);
    write_reg(CFG_TICK_STEP, 16'd1);
    pending_cmds.push_back(make_cmd(OP_USER, 8'd6, 8'hFF, 8'hFF, 8'hFF, EFF_BLINK, 0, 0));
    pending_cmds.push_back(make_cmd(OP_USER, 8'd7, 8'hFF, 8'hFF, 8'hFF, EFF_FADE, 0, 0));
    pending_cmds.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    write_reg(CFG_TICK_STEP, 16'd1000);
    write_reg(CFG_DEFAULT_PERIOD, 16'hFFFF);
    for (int n = 0; n < 95; n++) pending_cmds.push_back(random_cmd());
    wait_idle();

    send_idle_pct = 79;
    recv_idle_pct = 17;
    write_reg(CFG_TICK_STEP, 16'($urandom_range(1, 1000)));
    write_reg(CFG_DEFAULT_PERIOD, 16'($urandom_range(1, 3000)));
    for (int n = 0; n < 45; n++) pending_cmds.push_back(random_cmd());
    // sender pauses until every frame has drained
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    for (int n = 0; n < 50; n++) pending_cmds.push_back(random_cmd());
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_TICK_STEP, 16'($urandom_range(1, 1000)));
    write_reg(CFG_DEFAULT_PERIOD, 16'd1);
    hold_armed <= 1'b1;
    for (int n = 0; n < 95; n++) pending_cmds.push_back(random_cmd());
    wait_idle();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
